### hdl/cached_glyph_index_lookup_defines.svh
// Assertion macros shared by the glyph lookup RTL.
`ifndef CACHED_GLYPH_INDEX_LOOKUP_DEFINES_SVH
`define CACHED_GLYPH_INDEX_LOOKUP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define CGIL_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define CGIL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CGIL_ASSERT(label, ante, cons, msg)
`define CGIL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hdl/cgil_pkg.sv
// Shared constants and types for the cached glyph index lookup.
package cgil_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int CACHE_SLOTS = 32;
  localparam int GLYPH_BYTES = 32;

  localparam int TABLE_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int CACHE_IW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;

  localparam int CP_W      = 21;
  localparam int POS_W     = 12;
  localparam int IDX_W     = 12;
  localparam int GCOUNT_W  = 13;
  localparam int ADDR_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BITMAP_BASE = 1'b1;

  typedef struct packed {
    logic                invalidate;
    logic                lookup;
    logic                store;
    logic [CP_W-1:0]     codepoint;
    logic                found;
    logic [TABLE_AW-1:0] index;
  } cgil_cache_ctl_t;

  typedef struct packed {
    logic                hit;
    logic                found;
    logic [TABLE_AW-1:0] index;
  } cgil_cache_rsp_t;

endpackage

### hdl/cgil_table_ram.sv
// Codepoint table: single-port-write, registered-read synchronous memory.
module cgil_table_ram
  import cgil_pkg::*;
(
  input  logic                clk,
  input  logic                wr_en,
  input  logic [TABLE_AW-1:0] wr_addr,
  input  logic [CP_W-1:0]     wr_data,
  input  logic                rd_en,
  input  logic [TABLE_AW-1:0] rd_addr,
  output logic [CP_W-1:0]     rd_data
);

  logic [CP_W-1:0] mem_r [TABLE_DEPTH];
  logic [CP_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/cgil_cache.sv
// Fully associative lookup cache with round-robin replacement.
module cgil_cache
  import cgil_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cgil_cache_ctl_t ctl,
  output cgil_cache_rsp_t rsp
);

  logic [CP_W-1:0]        tag_r [CACHE_SLOTS];
  logic [CACHE_SLOTS-1:0] valid_r;
  logic [CACHE_IW-1:0]    ptr_r;
  logic [TABLE_AW:0]      data_mem_r [CACHE_SLOTS];
  logic [TABLE_AW:0]      rd_data_r;
  logic                   hit_r;

  logic [CACHE_SLOTS-1:0] match;
  logic [CACHE_IW-1:0]    hit_slot;

  always_comb begin
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      match[i] = valid_r[i] && (tag_r[i] == ctl.codepoint);
    end
  end

  // The lowest matching slot wins.
  always_comb begin
    hit_slot = '0;
    for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = CACHE_IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ptr_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (ctl.invalidate) begin
        valid_r <= '0;
        ptr_r   <= '0;
      end else if (ctl.store) begin
        valid_r[ptr_r] <= 1'b1;
        tag_r[ptr_r]   <= ctl.codepoint;
        if (ptr_r == CACHE_IW'(CACHE_SLOTS - 1)) begin
          ptr_r <= '0;
        end else begin
          ptr_r <= ptr_r + 1'b1;
        end
      end
      if (ctl.lookup) begin
        hit_r <= |match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.store && !ctl.invalidate) begin
      data_mem_r[ptr_r] <= {ctl.found, ctl.index};
    end
    if (ctl.lookup) begin
      rd_data_r <= data_mem_r[hit_slot];
    end
  end

  assign rsp.hit   = hit_r;
  assign rsp.found = rd_data_r[TABLE_AW];
  assign rsp.index = rd_data_r[TABLE_AW-1:0];

endmodule

### hdl/cached_glyph_index_lookup.sv
// Load items complete in their accept cycle and busy stays low. A lookup holds busy
// through PROBE, SEARCH and RESULT; SEARCH takes one step on a cache hit or an empty
// range, else one per bisection read (at most 13 for 4096 entries), one read per cycle.
// The result strobe marks the first idle cycle, in which the next item may be accepted.
// rst_n is synchronous: it clears the cache, the config registers, the strobe and the controller.
// Results cannot be stalled.
`include "cached_glyph_index_lookup_defines.svh"

module cached_glyph_index_lookup
  import cgil_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_operation,
  input  logic [POS_W-1:0]     in_entry_position,
  input  logic [CP_W-1:0]      in_entry_codepoint,
  input  logic [CP_W-1:0]      in_query_codepoint,
  output logic                 out_strobe,
  output logic                 out_found,
  output logic                 out_cache_hit,
  output logic [IDX_W-1:0]     out_glyph_index,
  output logic [ADDR_W-1:0]    out_glyph_address,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_PROBE, ST_SEARCH, ST_RESULT} state_t;

  state_t              state_r, state_nxt;
  logic [CP_W-1:0]     cp_r, cp_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hi_r, hi_nxt;
  logic [TABLE_AW-1:0] mid_r, mid_nxt;
  logic                first_r, first_nxt;
  logic                res_found_r, res_found_nxt;
  logic                res_cache_r, res_cache_nxt;
  logic [TABLE_AW-1:0] res_idx_r, res_idx_nxt;
  logic [GCOUNT_W-1:0] gcount_r;
  logic [ADDR_W-1:0]   base_r;
  logic                out_strobe_r, out_strobe_nxt;
  logic                out_found_r, out_found_nxt;
  logic                out_cache_hit_r, out_cache_hit_nxt;
  logic [IDX_W-1:0]    out_index_r, out_index_nxt;
  logic [ADDR_W-1:0]   out_address_r, out_address_nxt;

  logic                tbl_we;
  logic                tbl_re;
  logic [TABLE_AW-1:0] tbl_raddr;
  logic [CP_W-1:0]     tbl_rdata;
  cgil_cache_ctl_t     cache_ctl;
  cgil_cache_rsp_t     cache_rsp;

  logic [CNT_W-1:0]    hi_init;
  logic [CNT_W-1:0]    lo_step;
  logic [CNT_W-1:0]    hi_step;
  logic [CNT_W:0]      mid_sum;
  logic                pos_ok;

  cgil_table_ram u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (TABLE_AW'(in_entry_position)),
    .wr_data (in_entry_codepoint),
    .rd_en   (tbl_re),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  cgil_cache u_cache (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cache_ctl),
    .rsp   (cache_rsp)
  );

  assign busy   = (state_r != ST_IDLE);
  assign pos_ok = (32'(in_entry_position) < 32'(TABLE_DEPTH));

  // The search bound saturates at the table depth.
  assign hi_init = (32'(gcount_r) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(gcount_r);

  // One bisection step, based on the entry read at mid_r.
  assign lo_step = (tbl_rdata < cp_r) ? (CNT_W'(mid_r) + 1'b1) : lo_r;
  assign hi_step = (tbl_rdata < cp_r) ? hi_r : CNT_W'(mid_r);
  assign mid_sum = (CNT_W + 1)'(lo_step) + (CNT_W + 1)'(hi_step);

  always_comb begin
    state_nxt         = state_r;
    cp_nxt            = cp_r;
    lo_nxt            = lo_r;
    hi_nxt            = hi_r;
    mid_nxt           = mid_r;
    first_nxt         = first_r;
    res_found_nxt     = res_found_r;
    res_cache_nxt     = res_cache_r;
    res_idx_nxt       = res_idx_r;
    out_strobe_nxt    = 1'b0;
    out_found_nxt     = out_found_r;
    out_cache_hit_nxt = out_cache_hit_r;
    out_index_nxt     = out_index_r;
    out_address_nxt   = out_address_r;
    tbl_we            = 1'b0;
    tbl_re            = 1'b0;
    tbl_raddr         = mid_r;
    cache_ctl         = '0;
    cache_ctl.codepoint = cp_r;
    cache_ctl.found     = res_found_r;
    cache_ctl.index     = res_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_operation == OP_LOOKUP) begin
            cp_nxt    = in_query_codepoint;
            state_nxt = ST_PROBE;
          end else begin
            tbl_we               = pos_ok;
            cache_ctl.invalidate = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        cache_ctl.lookup = 1'b1;
        lo_nxt           = '0;
        hi_nxt           = hi_init;
        first_nxt        = 1'b1;
        mid_nxt          = TABLE_AW'(hi_init >> 1);
        tbl_raddr        = TABLE_AW'(hi_init >> 1);
        tbl_re           = (hi_init != '0);
        state_nxt        = ST_SEARCH;
      end
      ST_SEARCH: begin
        first_nxt     = 1'b0;
        res_cache_nxt = 1'b0;
        res_found_nxt = 1'b0;
        res_idx_nxt   = '0;
        if (first_r && cache_rsp.hit) begin
          res_cache_nxt = 1'b1;
          res_found_nxt = cache_rsp.found;
          res_idx_nxt   = cache_rsp.found ? cache_rsp.index : '0;
          state_nxt     = ST_RESULT;
        end else if (lo_r >= hi_r) begin
          state_nxt = ST_RESULT;
        end else if (tbl_rdata == cp_r) begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = mid_r;
          state_nxt     = ST_RESULT;
        end else begin
          lo_nxt = lo_step;
          hi_nxt = hi_step;
          if (lo_step < hi_step) begin
            mid_nxt   = TABLE_AW'(mid_sum >> 1);
            tbl_raddr = TABLE_AW'(mid_sum >> 1);
            tbl_re    = 1'b1;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        // Misses go into the cache as well; cache hits are not stored again.
        cache_ctl.store   = !res_cache_r;
        out_strobe_nxt    = 1'b1;
        out_found_nxt     = res_found_r;
        out_cache_hit_nxt = res_cache_r;
        out_index_nxt     = IDX_W'(res_idx_r);
        out_address_nxt   = res_found_r
                            ? (base_r + ADDR_W'(32'(res_idx_r) * 32'(GLYPH_BYTES)))
                            : '0;
        state_nxt         = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      gcount_r     <= '0;
      base_r       <= '0;
    end else begin
      state_r         <= state_nxt;
      cp_r            <= cp_nxt;
      lo_r            <= lo_nxt;
      hi_r            <= hi_nxt;
      mid_r           <= mid_nxt;
      first_r         <= first_nxt;
      res_found_r     <= res_found_nxt;
      res_cache_r     <= res_cache_nxt;
      res_idx_r       <= res_idx_nxt;
      out_strobe_r    <= out_strobe_nxt;
      out_found_r     <= out_found_nxt;
      out_cache_hit_r <= out_cache_hit_nxt;
      out_index_r     <= out_index_nxt;
      out_address_r   <= out_address_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GLYPH_COUNT: gcount_r <= GCOUNT_W'(cfg_wdata);
          REG_BITMAP_BASE: base_r   <= ADDR_W'(cfg_wdata);
          default: ;
        endcase
      end
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_found         = out_found_r;
  assign out_cache_hit     = out_cache_hit_r;
  assign out_glyph_index   = out_index_r;
  assign out_glyph_address = out_address_r;

  // A result only follows a lookup that kept the block busy.
  `CGIL_ASSERT(a_strobe_after_busy, out_strobe, $past(busy), "result without a busy lookup")
  // Each result occupies exactly one cycle.
  `CGIL_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held too long")
  // A negative answer carries a zero index and address.
  `CGIL_ASSERT(a_miss_zero, out_strobe && !out_found,
    out_glyph_index == '0 && out_glyph_address == '0, "miss result carries nonzero payload")
  // A load item completes in its accept cycle.
  `CGIL_ASSERT_NEXT(a_load_no_busy, start && !busy && in_operation == OP_LOAD, !busy,
    "load item left the block busy")

endmodule
